@@ design/tghq_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helpers of the triangulated grid height query core
// no dependencies

package tghq_pkg;

    localparam int GRID_POINTS = 9;
    localparam int CELL_SIZE   = 24;

    localparam int POS_W  = 16;
    localparam int FRAC_W = 8;
    localparam int Q_W    = POS_W - FRAC_W;
    localparam int HGT_W  = 8;
    localparam int BLK_W  = 8;

    localparam int CELL_D     = CELL_SIZE * (2 ** FRAC_W);
    localparam int SIDE       = CELL_D * (GRID_POINTS - 1);
    localparam int IX_W       = $clog2(GRID_POINTS);
    localparam int GRID_DEPTH = GRID_POINTS * GRID_POINTS;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int RX_W       = $clog2(CELL_D);

    // cell index by reciprocal, one correction step
    localparam int RECIP_SH   = 16;
    localparam int RECIP      = (2 ** RECIP_SH) / CELL_SIZE;
    localparam int RECIP_W    = RECIP_SH + 1;
    localparam int EST_PROD_W = Q_W + RECIP_W;
    localparam int MUL_W      = Q_W + 8;

    // plane evaluation widths
    localparam int H_W  = HGT_W + 1;
    localparam int B_W  = H_W + 2;
    localparam int N_W  = B_W + RX_W + 2;
    localparam int NU_W = N_W - 1;

    // final divide by cell size
    localparam int DIV_SH      = NU_W;
    localparam int DIV_RECIP   = (2 ** DIV_SH) / CELL_SIZE;
    localparam int DIV_RECIP_W = DIV_SH + 1;
    localparam int DIV_PROD_W  = NU_W + DIV_RECIP_W;

    localparam int OUT_H_W    = 17;
    localparam int HEIGHT_MAX = ((2 ** HGT_W) - 1) * 2 * (2 ** FRAC_W);

    localparam int TX_W  = BLK_W + IX_W;
    localparam int TXY_W = 2 * TX_W;

    localparam logic [31:0] HASH_C1 = 32'h0CCAC033;
    localparam logic [31:0] HASH_C2 = 32'h421BE3BD;
    localparam logic [31:0] HASH_C3 = 32'h6C1AC587;
    localparam logic [31:0] HASH_C4 = 32'h519B8F25;

    localparam int LAST_ST = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_Y = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  grid_col;
        logic [3:0]  grid_row;
        logic [7:0]  corner_height;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_in_word;

    typedef struct packed {
        logic [OUT_H_W-1:0] height;
        logic               split_nesw;
    } t_out_word;

    typedef struct packed {
        logic [IX_W-1:0] ix;
        logic [IX_W-1:0] iy;
        logic [RX_W-1:0] rx;
        logic [RX_W-1:0] ry;
    } t_loc;

    typedef struct packed {
        logic [ADDR_W-1:0] a00;
        logic [ADDR_W-1:0] a10;
        logic [ADDR_W-1:0] a01;
        logic [ADDR_W-1:0] a11;
    } t_corner_addr;

    typedef struct packed {
        logic [HGT_W-1:0] h00;
        logic [HGT_W-1:0] h10;
        logic [HGT_W-1:0] h01;
        logic [HGT_W-1:0] h11;
    } t_corners;

    function automatic logic [ADDR_W-1:0] f_grid_addr(input int unsigned col,
                                                      input int unsigned row);
        return ADDR_W'(col * GRID_POINTS + row);
    endfunction

endpackage

@@ design/triangulated_grid_height_query_core.sv @@
`timescale 1ns / 1ps
// throughput: one word per cycle while the output is not stalled, writes and queries mixed, set by the dual read ports
// the grid is held twice so all four corners are fetched in the same cycle
// reset clears all stage valids and block_x / block_y; grid contents stay
// undefined until written, there is no clearing pass
module triangulated_grid_height_query_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  tghq_pkg::t_in_word                    i_in_word,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output tghq_pkg::t_out_word                   o_out_word,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tghq_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tghq_pkg::BLK_W-1:0]            i_cfg_data
);

    logic [tghq_pkg::LAST_ST:1]   r_v;
    logic [tghq_pkg::LAST_ST+1:1] rdy;
    logic [tghq_pkg::LAST_ST:1]   src;
    logic [tghq_pkg::LAST_ST:1]   ld;
    logic [tghq_pkg::LAST_ST:1]   n_v;
    logic                         wr_en;
    logic                         wr_in_range;

    logic [tghq_pkg::BLK_W-1:0]   r_block_x;
    logic [tghq_pkg::BLK_W-1:0]   r_block_y;

    tghq_pkg::t_in_word           r_in;
    logic                         r_op2;
    logic [3:0]                   r_wr_col;
    logic [3:0]                   r_wr_row;
    logic [tghq_pkg::HGT_W-1:0]   r_wr_height;
    logic [tghq_pkg::ADDR_W-1:0]  wr_addr;

    tghq_pkg::t_loc               loc;
    tghq_pkg::t_corner_addr       caddr;
    tghq_pkg::t_corners           corners;
    logic                         split;
    tghq_pkg::t_out_word          res_word;
    tghq_pkg::t_out_word          r_out;

    // elastic stage handshake, writes leave after stage 2, where in-range ones write the ram
    always_comb begin
        rdy[tghq_pkg::LAST_ST+1] = i_out_ready;
        for (int k = tghq_pkg::LAST_ST; k >= 1; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        src[1] = i_in_valid;
        for (int k = 2; k <= tghq_pkg::LAST_ST; k++) begin
            src[k] = r_v[k-1];
        end
        src[3] = r_v[2] && (r_op2 == tghq_pkg::OP_QUERY);
        ld  = rdy[tghq_pkg::LAST_ST:1] & src;
        n_v = (rdy[tghq_pkg::LAST_ST:1] & src) | (~rdy[tghq_pkg::LAST_ST:1] & r_v);
        wr_in_range = (32'(r_wr_col) < tghq_pkg::GRID_POINTS)
                   && (32'(r_wr_row) < tghq_pkg::GRID_POINTS);
        wr_en   = rdy[3] && r_v[2] && (r_op2 == tghq_pkg::OP_WRITE) && wr_in_range;
        wr_addr = tghq_pkg::f_grid_addr(32'(r_wr_col), 32'(r_wr_row));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_x <= '0;
            r_block_y <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tghq_pkg::CFG_BLOCK_X: r_block_x <= i_cfg_data;
                tghq_pkg::CFG_BLOCK_Y: r_block_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r_in <= i_in_word;
        end
        if (ld[2]) begin
            r_op2       <= r_in.opcode;
            r_wr_col    <= r_in.grid_col;
            r_wr_row    <= r_in.grid_row;
            r_wr_height <= r_in.corner_height;
        end
        if (ld[tghq_pkg::LAST_ST]) begin
            r_out <= res_word;
        end
    end

    tghq_locate u_locate (
        .i_clk   (i_clk),
        .i_ld2   (ld[2]),
        .i_pos_x (r_in.pos_x),
        .i_pos_y (r_in.pos_y),
        .o_loc   (loc),
        .o_addr  (caddr)
    );

    // row pair iy on one copy, row pair iy+1 on the other
    tghq_ram #(
        .DATA_W (tghq_pkg::HGT_W),
        .DEPTH  (tghq_pkg::GRID_DEPTH),
        .ADDR_W (tghq_pkg::ADDR_W)
    ) u_ram_lo (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (r_wr_height),
        .i_rd_en    (ld[3]),
        .i_rd_addr0 (caddr.a00),
        .i_rd_addr1 (caddr.a10),
        .o_rd_data0 (corners.h00),
        .o_rd_data1 (corners.h10)
    );

    tghq_ram #(
        .DATA_W (tghq_pkg::HGT_W),
        .DEPTH  (tghq_pkg::GRID_DEPTH),
        .ADDR_W (tghq_pkg::ADDR_W)
    ) u_ram_hi (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (r_wr_height),
        .i_rd_en    (ld[3]),
        .i_rd_addr0 (caddr.a01),
        .i_rd_addr1 (caddr.a11),
        .o_rd_data0 (corners.h01),
        .o_rd_data1 (corners.h11)
    );

    tghq_hash u_hash (
        .i_clk     (i_clk),
        .i_ld      (ld),
        .i_block_x (r_block_x),
        .i_block_y (r_block_y),
        .i_loc     (loc),
        .o_split   (split)
    );

    tghq_interp u_interp (
        .i_clk     (i_clk),
        .i_ld      (ld),
        .i_loc     (loc),
        .i_corners (corners),
        .i_split   (split),
        .o_word    (res_word)
    );

    assign o_in_ready  = rdy[1];
    assign o_out_valid = r_v[tghq_pkg::LAST_ST];
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_v == '0))
        else $error("pipeline not empty after reset");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[tghq_pkg::LAST_ST] |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_height_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_word.height) <= tghq_pkg::HEIGHT_MAX))
        else $error("height above cap");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !ld[3])
        else $error("grid write and corner read in one cycle");

endmodule

@@ design/tghq_ram.sv @@
`timescale 1ns / 1ps
// generic synchronous ram, one write port and two registered read ports
// no dependencies

module tghq_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 81,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr0,
    input  logic [ADDR_W-1:0] i_rd_addr1,
    output logic [DATA_W-1:0] o_rd_data0,
    output logic [DATA_W-1:0] o_rd_data1
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data0;
    logic [DATA_W-1:0] r_rd_data1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data0 <= r_mem[i_rd_addr0];
            r_rd_data1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd_data0;
    assign o_rd_data1 = r_rd_data1;

endmodule

@@ design/tghq_locate.sv @@
`timescale 1ns / 1ps
// position clamp, split into cell index and offset, corner addresses
// depends on tghq_pkg

module tghq_locate (
    input  logic                             i_clk,
    input  logic                             i_ld2,
    input  logic [tghq_pkg::POS_W-1:0]       i_pos_x,
    input  logic [tghq_pkg::POS_W-1:0]       i_pos_y,
    output tghq_pkg::t_loc                   o_loc,
    output tghq_pkg::t_corner_addr           o_addr
);

    typedef struct packed {
        logic [tghq_pkg::IX_W-1:0] idx;
        logic [tghq_pkg::RX_W-1:0] off;
    } t_axis;

    function automatic t_axis f_axis(input logic [tghq_pkg::Q_W-1:0]    q,
                                     input logic [tghq_pkg::FRAC_W-1:0] frac,
                                     input logic [tghq_pkg::Q_W-1:0]    est);
        logic [tghq_pkg::MUL_W-1:0] rem;
        logic [tghq_pkg::Q_W-1:0]   idx;
        t_axis                      a;
        rem = tghq_pkg::MUL_W'(q)
            - tghq_pkg::MUL_W'(est) * tghq_pkg::MUL_W'(tghq_pkg::CELL_SIZE);
        idx = est;
        if (rem >= tghq_pkg::MUL_W'(tghq_pkg::CELL_SIZE)) begin
            idx = est + tghq_pkg::Q_W'(1);
            rem = rem - tghq_pkg::MUL_W'(tghq_pkg::CELL_SIZE);
        end
        a.idx = tghq_pkg::IX_W'(idx);
        a.off = tghq_pkg::RX_W'((32'(rem) << tghq_pkg::FRAC_W) | 32'(frac));
        return a;
    endfunction

    function automatic logic [tghq_pkg::Q_W-1:0] f_est(
        input logic [tghq_pkg::Q_W-1:0] q
    );
        logic [tghq_pkg::EST_PROD_W-1:0] prod;
        prod = tghq_pkg::EST_PROD_W'(q) * tghq_pkg::EST_PROD_W'(tghq_pkg::RECIP);
        return prod[tghq_pkg::RECIP_SH +: tghq_pkg::Q_W];
    endfunction

    logic [tghq_pkg::POS_W-1:0]  px_c;
    logic [tghq_pkg::POS_W-1:0]  py_c;
    logic [tghq_pkg::Q_W-1:0]    n_q_x;
    logic [tghq_pkg::Q_W-1:0]    n_q_y;
    logic [tghq_pkg::Q_W-1:0]    r_q_x;
    logic [tghq_pkg::Q_W-1:0]    r_q_y;
    logic [tghq_pkg::FRAC_W-1:0] r_frac_x;
    logic [tghq_pkg::FRAC_W-1:0] r_frac_y;
    logic [tghq_pkg::Q_W-1:0]    r_est_x;
    logic [tghq_pkg::Q_W-1:0]    r_est_y;
    t_axis                       ax_x;
    t_axis                       ax_y;
    logic [tghq_pkg::IX_W-1:0]   ix1;
    logic [tghq_pkg::IX_W-1:0]   iy1;

    // clamp to block side
    always_comb begin
        px_c = (32'(i_pos_x) > 32'(tghq_pkg::SIDE)) ? tghq_pkg::POS_W'(tghq_pkg::SIDE)
                                                    : i_pos_x;
        py_c = (32'(i_pos_y) > 32'(tghq_pkg::SIDE)) ? tghq_pkg::POS_W'(tghq_pkg::SIDE)
                                                    : i_pos_y;
        n_q_x = px_c[tghq_pkg::POS_W-1:tghq_pkg::FRAC_W];
        n_q_y = py_c[tghq_pkg::POS_W-1:tghq_pkg::FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld2) begin
            r_q_x    <= n_q_x;
            r_q_y    <= n_q_y;
            r_frac_x <= px_c[tghq_pkg::FRAC_W-1:0];
            r_frac_y <= py_c[tghq_pkg::FRAC_W-1:0];
            r_est_x  <= f_est(n_q_x);
            r_est_y  <= f_est(n_q_y);
        end
    end

    always_comb begin
        ax_x = f_axis(r_q_x, r_frac_x, r_est_x);
        ax_y = f_axis(r_q_y, r_frac_y, r_est_y);
        // neighbors clamp to last grid line
        ix1 = (32'(ax_x.idx) >= tghq_pkg::GRID_POINTS - 1) ? ax_x.idx
                                                           : ax_x.idx + tghq_pkg::IX_W'(1);
        iy1 = (32'(ax_y.idx) >= tghq_pkg::GRID_POINTS - 1) ? ax_y.idx
                                                           : ax_y.idx + tghq_pkg::IX_W'(1);
        o_loc.ix   = ax_x.idx;
        o_loc.iy   = ax_y.idx;
        o_loc.rx   = ax_x.off;
        o_loc.ry   = ax_y.off;
        o_addr.a00 = tghq_pkg::f_grid_addr(32'(ax_x.idx), 32'(ax_y.idx));
        o_addr.a10 = tghq_pkg::f_grid_addr(32'(ix1), 32'(ax_y.idx));
        o_addr.a01 = tghq_pkg::f_grid_addr(32'(ax_x.idx), 32'(iy1));
        o_addr.a11 = tghq_pkg::f_grid_addr(32'(ix1), 32'(iy1));
    end

endmodule

@@ design/tghq_hash.sv @@
`timescale 1ns / 1ps
// cell hash over global cell coordinates, selects the split diagonal
// depends on tghq_pkg

module tghq_hash (
    input  logic                       i_clk,
    input  logic [tghq_pkg::LAST_ST:1] i_ld,
    input  logic [tghq_pkg::BLK_W-1:0] i_block_x,
    input  logic [tghq_pkg::BLK_W-1:0] i_block_y,
    input  tghq_pkg::t_loc             i_loc,
    output logic                       o_split
);

    logic [tghq_pkg::TX_W-1:0]  r_tx_base;
    logic [tghq_pkg::TX_W-1:0]  r_ty_base;
    logic [tghq_pkg::IX_W-1:0]  r_ix;
    logic [tghq_pkg::IX_W-1:0]  r_iy;
    logic [tghq_pkg::TX_W-1:0]  tx;
    logic [tghq_pkg::TX_W-1:0]  ty;
    logic [tghq_pkg::TXY_W-1:0] n_txy;
    logic [31:0]                n_a;
    logic [31:0]                n_b;
    logic [tghq_pkg::TXY_W-1:0] r_txy;
    logic [31:0]                r_a;
    logic [31:0]                r_b;
    logic [31:0]                r_m1;
    logic [31:0]                r_pre;
    logic [31:0]                hv;

    // block origin in cells, static between config writes
    always_ff @(posedge i_clk) begin
        r_tx_base <= tghq_pkg::TX_W'(32'(i_block_x) * (tghq_pkg::GRID_POINTS - 1));
        r_ty_base <= tghq_pkg::TX_W'(32'(i_block_y) * (tghq_pkg::GRID_POINTS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r_ix <= i_loc.ix;
            r_iy <= i_loc.iy;
        end
    end

    always_comb begin
        tx    = r_tx_base + tghq_pkg::TX_W'(r_ix);
        ty    = r_ty_base + tghq_pkg::TX_W'(r_iy);
        n_txy = tghq_pkg::TXY_W'(tx) * tghq_pkg::TXY_W'(ty);
        n_a   = 32'(tx) * tghq_pkg::HASH_C2;
        n_b   = 32'(ty) * tghq_pkg::HASH_C3;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[4]) begin
            r_txy <= n_txy;
            r_a   <= n_a;
            r_b   <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[5]) begin
            r_m1  <= 32'(r_txy) * tghq_pkg::HASH_C1;
            r_pre <= r_b - r_a - tghq_pkg::HASH_C4;
        end
    end

    assign hv      = r_m1 + r_pre;
    assign o_split = hv[31];

endmodule

@@ design/tghq_interp.sv @@
`timescale 1ns / 1ps
// triangle select, plane evaluation and scaling to 1/512 units
// depends on tghq_pkg

module tghq_interp (
    input  logic                       i_clk,
    input  logic [tghq_pkg::LAST_ST:1] i_ld,
    input  tghq_pkg::t_loc             i_loc,
    input  tghq_pkg::t_corners         i_corners,
    input  logic                       i_split,
    output tghq_pkg::t_out_word        o_word
);

    logic [tghq_pkg::RX_W-1:0]        r_rx3, r_ry3, r_rx4, r_ry4, r_rx5, r_ry5;
    logic [tghq_pkg::RX_W-1:0]        r_rx6, r_ry6;
    tghq_pkg::t_corners               r_h4, r_h5;
    logic signed [tghq_pkg::B_W-1:0]  h00, h10, h01, h11;
    logic signed [tghq_pkg::B_W-1:0]  n_base, n_ax, n_ay;
    logic signed [tghq_pkg::B_W-1:0]  r_base, r_ax, r_ay;
    logic                             r_split6, r_split7, r_split8;
    logic                             upper;
    logic signed [tghq_pkg::N_W-1:0]  base_e, ax_e, ay_e, rx_e, ry_e, d_e, n_sum;
    logic [tghq_pkg::NU_W-1:0]        n_n, r_n, r_n8;
    logic [tghq_pkg::DIV_PROD_W-1:0]  r_prod;
    logic [tghq_pkg::NU_W-1:0]        q, qc, rem, res;

    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r_rx3 <= i_loc.rx;
            r_ry3 <= i_loc.ry;
        end
        if (i_ld[4]) begin
            r_rx4 <= r_rx3;
            r_ry4 <= r_ry3;
            r_h4  <= i_corners;
        end
        if (i_ld[5]) begin
            r_rx5 <= r_rx4;
            r_ry5 <= r_ry4;
            r_h5  <= r_h4;
        end
    end

    // pick the triangle and its plane: base + ax*x/d + ay*y/d
    always_comb begin
        h00 = signed'(tghq_pkg::B_W'({r_h5.h00, 1'b0}));
        h10 = signed'(tghq_pkg::B_W'({r_h5.h10, 1'b0}));
        h01 = signed'(tghq_pkg::B_W'({r_h5.h01, 1'b0}));
        h11 = signed'(tghq_pkg::B_W'({r_h5.h11, 1'b0}));
        if (i_split) begin
            upper = ((tghq_pkg::RX_W+1)'(r_rx5) + (tghq_pkg::RX_W+1)'(r_ry5))
                  > (tghq_pkg::RX_W+1)'(tghq_pkg::CELL_D);
        end else begin
            upper = r_ry5 > r_rx5;
        end
        if (i_split && upper) begin
            n_base = h10 + h01 - h11;
            n_ax   = h11 - h01;
            n_ay   = h11 - h10;
        end else if (i_split) begin
            n_base = h00;
            n_ax   = h10 - h00;
            n_ay   = h01 - h00;
        end else if (upper) begin
            n_base = h00;
            n_ax   = h11 - h01;
            n_ay   = h01 - h00;
        end else begin
            n_base = h00;
            n_ax   = h10 - h00;
            n_ay   = h11 - h10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[6]) begin
            r_base   <= n_base;
            r_ax     <= n_ax;
            r_ay     <= n_ay;
            r_rx6    <= r_rx5;
            r_ry6    <= r_ry5;
            r_split6 <= i_split;
        end
    end

    always_comb begin
        base_e = tghq_pkg::N_W'(r_base);
        ax_e   = tghq_pkg::N_W'(r_ax);
        ay_e   = tghq_pkg::N_W'(r_ay);
        rx_e   = signed'(tghq_pkg::N_W'(r_rx6));
        ry_e   = signed'(tghq_pkg::N_W'(r_ry6));
        d_e    = signed'(tghq_pkg::N_W'(tghq_pkg::CELL_D));
        n_sum  = base_e * d_e + ax_e * rx_e + ay_e * ry_e;
        n_n    = n_sum[tghq_pkg::N_W-1] ? '0 : n_sum[tghq_pkg::NU_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[7]) begin
            r_n      <= n_n;
            r_split7 <= r_split6;
        end
        if (i_ld[8]) begin
            r_prod   <= tghq_pkg::DIV_PROD_W'(r_n)
                      * tghq_pkg::DIV_PROD_W'(tghq_pkg::DIV_RECIP);
            r_n8     <= r_n;
            r_split8 <= r_split7;
        end
    end

    // quotient by cell size, one correction step, capped
    always_comb begin
        q   = r_prod[tghq_pkg::DIV_SH +: tghq_pkg::NU_W];
        qc  = q * tghq_pkg::NU_W'(tghq_pkg::CELL_SIZE);
        rem = r_n8 - qc;
        res = (rem >= tghq_pkg::NU_W'(tghq_pkg::CELL_SIZE)) ? q + tghq_pkg::NU_W'(1) : q;
        o_word.height = (res > tghq_pkg::NU_W'(tghq_pkg::HEIGHT_MAX))
                      ? tghq_pkg::OUT_H_W'(tghq_pkg::HEIGHT_MAX)
                      : res[tghq_pkg::OUT_H_W-1:0];
        o_word.split_nesw = r_split8;
    end

endmodule
